FILE: src/dgmg_pkg.sv
// ============================================================================
// Double Gaussian model package
// Shared constants, the exponential table and the structs that pass between
// the top level and the per-Gaussian pipeline.
// ============================================================================
package dgmg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int E_W       = FRAC_BITS + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_TWO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TWO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_TWO     = 3'd6;

    // Pipeline stage positions inside one Gaussian lane.
    localparam int V_STEPS   = 35;                  // ratio divider, one bit a stage
    localparam int EXP_STEPS = 13;                  // one table multiply a stage
    localparam int G_STEPS   = 32;                  // gradient dividers
    localparam int S_V       = 1 + V_STEPS;         // ratio ready
    localparam int S_ARG     = S_V + 1;             // squared ratio, v*v partials
    localparam int S_V2      = S_ARG + 1;           // v*v / 2^32
    localparam int S_EXP     = S_ARG + EXP_STEPS;   // table product done
    localparam int S_E       = S_EXP + 1;           // interpolated exponential
    localparam int S_MAE     = S_E + 1;             // |A| * E
    localparam int S_PROD    = S_MAE + 1;           // split products
    localparam int S_SUM     = S_PROD + 1;          // products summed
    localparam int S_INIT    = S_SUM + 1;           // overflow check, divider start
    localparam int GAUSS_LAT = S_INIT + G_STEPS;
    localparam int PIPE_LAT  = GAUSS_LAT + 1;

    // exp(-2^k) in Q.30, k from 4 down to -8.
    localparam logic [29:0] EXP_TAB [0:EXP_STEPS-1] = '{
        30'd121, 30'd360200, 30'd19666267, 30'd145315154, 30'd395007542,
        30'd651257337, 30'd836230973, 30'd947573834, 30'd1008687095,
        30'd1040706260, 30'd1057095000, 30'd1065385899, 30'd1069555701
    };

    typedef struct packed {
        logic        aneg;
        logic [31:0] amag;
        logic [31:0] center;
        logic [30:0] width;
    } gauss_cfg_t;

    typedef struct packed {
        logic           far;
        logic           dneg;
        logic [E_W-1:0] e;
        logic [31:0]    term;
        logic           gc_sat;
        logic [31:0]    gc_q;
        logic           gw_sat;
        logic [31:0]    gw_q;
    } gauss_res_t;

endpackage

FILE: src/double_gaussian_model_gradient.sv
// ============================================================================
// Double Gaussian model with gradient
// Baseline plus two Gaussians in signed Q16.16, with the six partial
// derivatives a least-squares fitter needs.
// ============================================================================
// Usage: load the seven parameters through the write port (cfg_wr_en,
// cfg_index, cfg_data) while no sample is in flight. Samples enter on the
// in_valid/in_ready channel, one transfer per cycle; each gives one result
// transfer on out_valid/out_ready carrying the model value, the six gradients
// and a saturation flag.
// The pipeline has 88 register stages. Throughput is one sample per cycle
// while out_ready does not hold it; the depth comes from the bit-per-stage
// dividers (35 stages for the ratio, 32 for the gradients) and the 13-stage
// exponential product.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the parameter reset values
// (amplitudes and widths 1.0, centers and baseline 0).
// ============================================================================
module double_gaussian_model_gradient
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dgmg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               sample_x,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               model_value,
    output logic [16:0]                      grad_amp_one,
    output logic signed [31:0]               grad_center_one,
    output logic signed [31:0]               grad_width_one,
    output logic [16:0]                      grad_amp_two,
    output logic signed [31:0]               grad_center_two,
    output logic signed [31:0]               grad_width_two,
    output logic                             saturated
);
    import dgmg_pkg::*;

    // Returns {clipped, value} for a sign and a magnitude.
    function automatic logic [32:0] clip_mag(input logic neg, input logic [32:0] mag);
        if (neg)
        begin
            if (mag > 33'h0_8000_0000)
                clip_mag = {1'b1, 32'h8000_0000};
            else
                clip_mag = {1'b0, 32'(33'd0 - mag)};
        end
        else
        begin
            if (mag > 33'h0_7FFF_FFFF)
                clip_mag = {1'b1, 32'h7FFF_FFFF};
            else
                clip_mag = {1'b0, mag[31:0]};
        end
    endfunction

    logic signed [31:0] baseline_reg;
    logic signed [31:0] amp_one_reg, amp_two_reg;
    logic [31:0]        center_one_reg, center_two_reg;
    logic [30:0]        width_one_reg, width_two_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg   <= '0;
            amp_one_reg    <= 32'sd65536;
            center_one_reg <= '0;
            width_one_reg  <= 31'd65536;
            amp_two_reg    <= 32'sd65536;
            center_two_reg <= '0;
            width_two_reg  <= 31'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BASELINE:      baseline_reg   <= cfg_data;
                CFG_AMPLITUDE_ONE: amp_one_reg    <= cfg_data;
                CFG_CENTER_ONE:    center_one_reg <= cfg_data;
                CFG_WIDTH_ONE:     width_one_reg  <= cfg_data[30:0];
                CFG_AMPLITUDE_TWO: amp_two_reg    <= cfg_data;
                CFG_CENTER_TWO:    center_two_reg <= cfg_data;
                CFG_WIDTH_TWO:     width_two_reg  <= cfg_data[30:0];
                default:           ;
            endcase
        end
    end

    // A zero width behaves as the smallest step.
    gauss_cfg_t cfg_one, cfg_two;
    always_comb
    begin
        cfg_one.aneg   = amp_one_reg[31];
        cfg_one.amag   = amp_one_reg[31] ? 32'(-amp_one_reg) : amp_one_reg;
        cfg_one.center = center_one_reg;
        cfg_one.width  = (width_one_reg == '0) ? 31'd1 : width_one_reg;
        cfg_two.aneg   = amp_two_reg[31];
        cfg_two.amag   = amp_two_reg[31] ? 32'(-amp_two_reg) : amp_two_reg;
        cfg_two.center = center_two_reg;
        cfg_two.width  = (width_two_reg == '0) ? 31'd1 : width_two_reg;
    end

    logic vld_reg [1:PIPE_LAT];
    logic en;
    assign en        = !vld_reg[PIPE_LAT] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= PIPE_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= PIPE_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    gauss_res_t res_one, res_two;

    dgmg_gauss u_gauss_one
    (
        .clk      (clk),
        .en       (en),
        .sample_x (sample_x),
        .cfg      (cfg_one),
        .res      (res_one)
    );

    dgmg_gauss u_gauss_two
    (
        .clk      (clk),
        .en       (en),
        .sample_x (sample_x),
        .cfg      (cfg_two),
        .res      (res_two)
    );

    // Output stage: signs, clipping and the model sum.
    logic [32:0]        gc1, gw1, gc2, gw2;
    logic signed [33:0] t1, t2, sum;
    logic [31:0]        model_now;
    logic               model_flag;
    logic               flag_now;

    always_comb
    begin
        gc1 = clip_mag(cfg_one.aneg == res_one.dneg,
                       res_one.gc_sat ? 33'h1_0000_0000 : {1'b0, res_one.gc_q});
        gw1 = clip_mag(cfg_one.aneg,
                       res_one.gw_sat ? 33'h1_0000_0000 : {1'b0, res_one.gw_q});
        gc2 = clip_mag(cfg_two.aneg == res_two.dneg,
                       res_two.gc_sat ? 33'h1_0000_0000 : {1'b0, res_two.gc_q});
        gw2 = clip_mag(cfg_two.aneg,
                       res_two.gw_sat ? 33'h1_0000_0000 : {1'b0, res_two.gw_q});
        if (res_one.far)
        begin
            gc1 = '0;
            gw1 = '0;
            t1  = '0;
        end
        else
            t1 = cfg_one.aneg ? -$signed({2'b00, res_one.term})
                              : $signed({2'b00, res_one.term});
        if (res_two.far)
        begin
            gc2 = '0;
            gw2 = '0;
            t2  = '0;
        end
        else
            t2 = cfg_two.aneg ? -$signed({2'b00, res_two.term})
                              : $signed({2'b00, res_two.term});

        sum = 34'(baseline_reg) + t1 + t2;
        if (sum > 34'sd2147483647)
        begin
            model_now  = 32'h7FFF_FFFF;
            model_flag = 1'b1;
        end
        else if (sum < -34'sd2147483648)
        begin
            model_now  = 32'h8000_0000;
            model_flag = 1'b1;
        end
        else
        begin
            model_now  = sum[31:0];
            model_flag = 1'b0;
        end
        flag_now = model_flag | gc1[32] | gw1[32] | gc2[32] | gw2[32];
    end

    logic [31:0] model_value_reg, grad_center_one_reg, grad_width_one_reg;
    logic [31:0] grad_center_two_reg, grad_width_two_reg;
    logic [16:0] grad_amp_one_reg, grad_amp_two_reg;
    logic        saturated_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            model_value_reg     <= model_now;
            grad_amp_one_reg    <= res_one.far ? 17'd0 : 17'(res_one.e);
            grad_center_one_reg <= gc1[31:0];
            grad_width_one_reg  <= gw1[31:0];
            grad_amp_two_reg    <= res_two.far ? 17'd0 : 17'(res_two.e);
            grad_center_two_reg <= gc2[31:0];
            grad_width_two_reg  <= gw2[31:0];
            saturated_reg       <= flag_now;
        end
    end

    assign model_value     = model_value_reg;
    assign grad_amp_one    = grad_amp_one_reg;
    assign grad_center_one = grad_center_one_reg;
    assign grad_width_one  = grad_width_one_reg;
    assign grad_amp_two    = grad_amp_two_reg;
    assign grad_center_two = grad_center_two_reg;
    assign grad_width_two  = grad_width_two_reg;
    assign saturated       = saturated_reg;

endmodule

FILE: src/dgmg_gauss.sv
// ============================================================================
// Single Gaussian lane
// Evaluates exp(-a^2/(2w^2)), the term magnitude and the unsigned center and
// width gradient quotients for one Gaussian, one sample per enabled cycle.
// ============================================================================
module dgmg_gauss
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  sample_x,
    input  dgmg_pkg::gauss_cfg_t cfg,
    output dgmg_pkg::gauss_res_t res
);
    import dgmg_pkg::*;

    localparam int V_W   = V_STEPS;
    localparam int ARG_W = 21;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [31:0] div_step(input logic [30:0] rem, input logic din,
                                             input logic [30:0] d);
        logic [31:0] t;
        t = {rem, din};
        if (t >= {1'b0, d})
            div_step = {1'b1, 31'(t - {1'b0, d})};
        else
            div_step = {1'b0, t[30:0]};
    endfunction

    logic [30:0] w;
    assign w = cfg.width;

    // Stage 1: distance to the center and the far test.
    logic signed [32:0] diff;
    logic [31:0]        dmag;
    logic               far_now;
    assign diff    = 33'($signed(cfg.center)) - 33'(sample_x);
    assign dmag    = diff[32] ? 32'(-diff) : 32'(diff);
    assign far_now = {2'b00, dmag} >= {w, 3'b000};

    logic [31:0] m_reg;
    logic        far_reg  [1:GAUSS_LAT];
    logic        dneg_reg [1:GAUSS_LAT];

    // Ratio divider: v = floor(m * 2^32 / w).
    logic [30:0]    vrem_reg [1:V_STEPS-1];
    logic [V_W-1:0] vlq_reg  [1:V_STEPS];
    logic [30:0]    vrem_in  [0:V_STEPS-1];
    logic [V_W-1:0] vlq_in   [0:V_STEPS-1];
    logic [31:0]    vst      [0:V_STEPS-1];

    always_comb
    begin
        vrem_in[0] = 31'(m_reg >> 3);
        vlq_in[0]  = {m_reg[2:0], 32'b0};
        for (int j = 1; j < V_STEPS; j++)
        begin
            vrem_in[j] = vrem_reg[j];
            vlq_in[j]  = vlq_reg[j];
        end
        for (int j = 0; j < V_STEPS; j++)
            vst[j] = div_step(vrem_in[j], vlq_in[j][V_W-1], w);
    end

    logic [V_W-1:0] v;
    logic [18:0]    v16;
    assign v   = vlq_reg[V_STEPS];
    assign v16 = v[V_W-1:16];

    // Squared ratio, and the partial products of v*v.
    logic [ARG_W-1:0] arg_reg;
    logic [63:0]      pp0_reg;
    logic [34:0]      pp1_reg;
    logic [2:0]       vh_reg;
    logic [37:0]      v2_reg;
    logic [69:0]      vsq;
    logic [37:0]      v16sq;

    assign v16sq = 38'(v16) * 38'(v16);
    assign vsq   = (70'(vh_reg) * 70'(vh_reg) << 64) + (70'(pp1_reg) << 33)
                 + 70'(pp0_reg);

    // Exponential by table products.
    logic [30:0]      ep_reg  [1:EXP_STEPS];
    logic [ARG_W-1:0] ea_reg  [1:EXP_STEPS];
    logic [30:0]      ep_in   [0:EXP_STEPS-1];
    logic [ARG_W-1:0] ea_in   [0:EXP_STEPS-1];
    logic [60:0]      eprod   [0:EXP_STEPS-1];
    logic [30:0]      ep_out  [0:EXP_STEPS-1];

    always_comb
    begin
        ep_in[0] = 31'h4000_0000;
        ea_in[0] = arg_reg;
        for (int k = 1; k < EXP_STEPS; k++)
        begin
            ep_in[k] = ep_reg[k];
            ea_in[k] = ea_reg[k];
        end
        for (int k = 0; k < EXP_STEPS; k++)
        begin
            eprod[k]  = 61'(ep_in[k]) * 61'(EXP_TAB[k]);
            ep_out[k] = ea_in[k][ARG_W-1-k] ? 31'(eprod[k] >> 30) : ep_in[k];
        end
    end

    // Linear interpolation over the low eight bits of the argument.
    logic [30:0]    pfin;
    logic [38:0]    pint;
    logic [30:0]    pcor;
    logic [E_W-1:0] e_now;
    assign pfin  = ep_reg[EXP_STEPS];
    assign pint  = 39'(pfin) * 39'(ea_reg[EXP_STEPS][7:0]);
    assign pcor  = pfin - 31'(pint >> 16);
    assign e_now = E_W'(pcor >> (30 - FRAC_BITS));

    logic [E_W-1:0]    e_reg;
    logic [32+E_W-1:0] mae_reg;
    logic [V_W-1:0]    vd_reg  [S_ARG:S_MAE];
    logic [37:0]       v2d_reg [S_V2+1:S_MAE];
    logic [E_W-1:0]    ed_reg  [S_MAE:GAUSS_LAT];
    logic [31:0]       td_reg  [S_PROD:GAUSS_LAT];

    // Split products of |A|*E by v and by v2.
    logic [66:0] clo_reg;
    logic [50:0] chi_reg;
    logic [69:0] wlo_reg;
    logic [53:0] whi_reg;
    logic [31:0] mae_lo;
    logic [15:0] mae_hi;
    assign mae_lo = mae_reg[31:0];
    assign mae_hi = 16'(mae_reg >> 32);

    logic [50:0] nc_reg;
    logic [53:0] nw_reg;
    logic [82:0] pc;
    logic [85:0] pw;
    assign pc = 83'(clo_reg) + (83'(chi_reg) << 32);
    assign pw = 86'(wlo_reg) + (86'(whi_reg) << 32);

    // Gradient dividers: floor(N / w) with N = product / 2^32.
    logic        csat_reg [0:G_STEPS];
    logic        wsat_reg [0:G_STEPS];
    logic [30:0] crem_reg [0:G_STEPS-1];
    logic [30:0] wrem_reg [0:G_STEPS-1];
    logic [31:0] clq_reg  [0:G_STEPS];
    logic [31:0] wlq_reg  [0:G_STEPS];
    logic [31:0] cst      [0:G_STEPS-1];
    logic [31:0] wst      [0:G_STEPS-1];

    always_comb
    begin
        for (int j = 0; j < G_STEPS; j++)
        begin
            cst[j] = div_step(crem_reg[j], clq_reg[j][31], w);
            wst[j] = div_step(wrem_reg[j], wlq_reg[j][31], w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg       <= dmag;
            far_reg[1]  <= far_now;
            dneg_reg[1] <= diff[32];
            for (int k = 2; k <= GAUSS_LAT; k++)
            begin
                far_reg[k]  <= far_reg[k-1];
                dneg_reg[k] <= dneg_reg[k-1];
            end

            for (int j = 0; j < V_STEPS; j++)
                vlq_reg[j+1] <= {vlq_in[j][V_W-2:0], vst[j][31]};
            for (int j = 0; j < V_STEPS - 1; j++)
                vrem_reg[j+1] <= vst[j][30:0];

            arg_reg <= ARG_W'(v16sq >> 17);
            pp0_reg <= 64'(v[31:0]) * 64'(v[31:0]);
            pp1_reg <= 35'(v[V_W-1:32]) * 35'(v[31:0]);
            vh_reg  <= v[V_W-1:32];
            v2_reg  <= 38'(vsq >> 32);

            for (int k = 0; k < EXP_STEPS; k++)
            begin
                ep_reg[k+1] <= ep_out[k];
                ea_reg[k+1] <= ea_in[k];
            end

            e_reg   <= e_now;
            mae_reg <= (32 + E_W)'(cfg.amag) * (32 + E_W)'(e_reg);

            vd_reg[S_ARG] <= v;
            for (int k = S_ARG + 1; k <= S_MAE; k++)
                vd_reg[k] <= vd_reg[k-1];
            v2d_reg[S_V2+1] <= v2_reg;
            for (int k = S_V2 + 2; k <= S_MAE; k++)
                v2d_reg[k] <= v2d_reg[k-1];
            ed_reg[S_MAE] <= e_reg;
            for (int k = S_MAE + 1; k <= GAUSS_LAT; k++)
                ed_reg[k] <= ed_reg[k-1];
            td_reg[S_PROD] <= 32'(mae_reg >> FRAC_BITS);
            for (int k = S_PROD + 1; k <= GAUSS_LAT; k++)
                td_reg[k] <= td_reg[k-1];

            clo_reg <= 67'(mae_lo) * 67'(vd_reg[S_MAE]);
            chi_reg <= 51'(mae_hi) * 51'(vd_reg[S_MAE]);
            wlo_reg <= 70'(mae_lo) * 70'(v2d_reg[S_MAE]);
            whi_reg <= 54'(mae_hi) * 54'(v2d_reg[S_MAE]);

            nc_reg <= 51'(pc >> 32);
            nw_reg <= 54'(pw >> 32);

            // A high part at or above w means the quotient leaves 32 bits.
            csat_reg[0] <= {12'b0, nc_reg[50:32]} >= w;
            wsat_reg[0] <= {9'b0, nw_reg[53:32]} >= w;
            crem_reg[0] <= 31'(nc_reg[50:32]);
            wrem_reg[0] <= 31'(nw_reg[53:32]);
            clq_reg[0]  <= nc_reg[31:0];
            wlq_reg[0]  <= nw_reg[31:0];
            for (int j = 0; j < G_STEPS; j++)
            begin
                csat_reg[j+1] <= csat_reg[j];
                wsat_reg[j+1] <= wsat_reg[j];
                clq_reg[j+1]  <= {clq_reg[j][30:0], cst[j][31]};
                wlq_reg[j+1]  <= {wlq_reg[j][30:0], wst[j][31]};
            end
            for (int j = 0; j < G_STEPS - 1; j++)
            begin
                crem_reg[j+1] <= cst[j][30:0];
                wrem_reg[j+1] <= wst[j][30:0];
            end
        end
    end

    always_comb
    begin
        res.far    = far_reg[GAUSS_LAT];
        res.dneg   = dneg_reg[GAUSS_LAT];
        res.e      = ed_reg[GAUSS_LAT];
        res.term   = td_reg[GAUSS_LAT];
        res.gc_sat = csat_reg[G_STEPS];
        res.gc_q   = clq_reg[G_STEPS];
        res.gw_sat = wsat_reg[G_STEPS];
        res.gw_q   = wlq_reg[G_STEPS];
    end

endmodule
